[hdl/rgb2yuv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types, constants and helpers of the RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int WIDTH_RESET       = 640;
    localparam int HEIGHT_RESET      = 480;

    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int ROW_W       = 12;
    localparam int PIX_W       = 8;
    localparam int QUARTER_W   = 6;
    localparam int PART_W      = 7;
    localparam int ENTRY_W     = 2 * PART_W;
    localparam int SUM_W       = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // BT.601 integer matrix
    localparam logic [SUM_W-1:0] COEF_YR  = 16'd66;
    localparam logic [SUM_W-1:0] COEF_YG  = 16'd129;
    localparam logic [SUM_W-1:0] COEF_YB  = 16'd25;
    localparam logic [SUM_W-1:0] COEF_CBR = 16'd38;
    localparam logic [SUM_W-1:0] COEF_CBG = 16'd74;
    localparam logic [SUM_W-1:0] COEF_CBB = 16'd112;
    localparam logic [SUM_W-1:0] COEF_CRR = 16'd112;
    localparam logic [SUM_W-1:0] COEF_CRG = 16'd94;
    localparam logic [SUM_W-1:0] COEF_CRB = 16'd18;
    localparam logic [PIX_W-1:0] LUMA_OFFSET = 8'd16;
    // 128 << 8, keeps the chroma sum non-negative
    localparam logic [SUM_W-1:0] CHROMA_BIAS = 16'd32768;

    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic frame_end;
    } pos_t;

    typedef struct packed {
        logic [PIX_W-1:0]     y;
        logic [QUARTER_W-1:0] qcb;
        logic [QUARTER_W-1:0] qcr;
    } pix_t;

    // even value in 2..hi
    function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        logic [CFG_W-1:0] e;
        e = {v[CFG_W-1:1], 1'b0};
        if (e < CFG_W'(2))
            e = CFG_W'(2);
        if (32'(e) > hi)
            e = CFG_W'(hi & 32'hFFFF_FFFE);
        return e;
    endfunction

endpackage
`default_nettype wire

[hdl/rgb_to_yuv420_converter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_top
// RGB pixels in raster order to per-pixel luma and 4:2:0 block chroma.
//
// Usage:
//   pixel channel (pixel_valid/pixel_ready) carries one RGB pixel a beat.
//   result channel (result_valid/result_ready) returns one beat per pixel:
//   luma, plus cb_out/cr_out with chroma_valid on the pixel that closes
//   a 2x2 block, and frame_end on the last pixel of the frame.
//   cfg channel writes frame_width (index 0) and frame_height (index 1);
//   cfg_ready is always high. Write only while no pixel is in flight; the
//   new size applies from the next pixel beat.
// Path: a taken pixel beat passes the input, matrix and output registers.
// Throughput: 1 pixel per clock while not stalled, one line store read and
//   one write per cycle; a same-cycle read of the written slot is forwarded.
// Reset: position counters cleared, width 640, height 480. The line store
//   is not cleared; every block row writes its slots before reading them.
// Stall: the result register holds while result_ready is low; the pipeline
//   keeps taking pixels until its three stages are full.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_top
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pixel_valid,
    output      logic                   pixel_ready,
    input  wire logic [PIX_W-1:0]       red_in,
    input  wire logic [PIX_W-1:0]       green_in,
    input  wire logic [PIX_W-1:0]       blue_in,
    output      logic                   result_valid,
    input  wire logic                   result_ready,
    output      logic [PIX_W-1:0]       luma,
    output      logic                   chroma_valid,
    output      logic [PIX_W-1:0]       cb_out,
    output      logic [PIX_W-1:0]       cr_out,
    output      logic                   frame_end,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int SLOT_W = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) - 1 : 1;
    localparam int COL_W  = SLOT_W + 1;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic              mat_valid_reg;
    logic              mat_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;
    logic              load_mat;
    logic              load_out;
    pos_t              pos;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] in_slot;
    pix_t              mat_pix;
    pos_t              mat_pos;
    logic [SLOT_W-1:0] mat_slot;

    assign load_out    = mat_valid_reg && (!out_valid_reg || result_ready);
    assign load_mat    = in_valid_reg && (!mat_valid_reg || load_out);
    assign pixel_ready = !in_valid_reg || load_mat;
    assign accept      = pixel_valid && pixel_ready;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        in_valid_next  = accept || (in_valid_reg && !load_mat);
        mat_valid_next = load_mat || (mat_valid_reg && !load_out);
        out_valid_next = load_out || (out_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mat_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mat_valid_reg <= mat_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    rgb2yuv_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .SLOT_W    (SLOT_W),
        .COL_W     (COL_W)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos),
        .slot      (slot)
    );

    rgb2yuv_matrix #(
        .SLOT_W (SLOT_W)
    ) u_matrix (
        .clk      (clk),
        .load_in  (accept),
        .load_mat (load_mat),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .pos_in   (pos),
        .slot_in  (slot),
        .in_slot  (in_slot),
        .mat_pix  (mat_pix),
        .mat_pos  (mat_pos),
        .mat_slot (mat_slot)
    );

    rgb2yuv_chroma #(
        .SLOT_W (SLOT_W)
    ) u_chroma (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_mat     (load_mat),
        .load_out     (load_out),
        .rd_slot      (in_slot),
        .mat_pix      (mat_pix),
        .mat_pos      (mat_pos),
        .mat_slot     (mat_slot),
        .luma         (luma),
        .chroma_valid (chroma_valid),
        .cb_out       (cb_out),
        .cr_out       (cr_out),
        .frame_end    (frame_end)
    );

endmodule
`default_nettype wire

[hdl/rgb2yuv_pos.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2yuv_pos
// Frame size registers and raster position counters of the incoming pixel.
// ----------------------------------------------------------------------------
module rgb2yuv_pos
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    parameter int SLOT_W    = 11,
    parameter int COL_W     = SLOT_W + 1
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   advance,
    output      pos_t                   pos,
    output      logic [SLOT_W-1:0]      slot
);

    localparam int CMP_W       = (COL_W > CFG_W) ? COL_W : CFG_W;
    localparam int W_RESET     = (WIDTH_RESET > MAX_WIDTH) ? (MAX_WIDTH & ~1) : WIDTH_RESET;
    localparam logic [CFG_W-1:0] W_RESET_M1 = CFG_W'(W_RESET - 1);
    localparam logic [ROW_W-1:0] H_RESET_M1 = ROW_W'(HEIGHT_RESET - 1);

    logic [CFG_W-1:0] width_m1_reg;
    logic [CFG_W-1:0] width_m1_next;
    logic [ROW_W-1:0] height_m1_reg;
    logic [ROW_W-1:0] height_m1_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             row_end;
    logic             frame_last;

    always_comb
    begin
        width_m1_next  = width_m1_reg;
        height_m1_next = height_m1_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                    width_m1_next = clamp_dim(cfg_data, MAX_WIDTH) - CFG_W'(1);
                REG_FRAME_HEIGHT:
                    height_m1_next = ROW_W'(clamp_dim(cfg_data, MAX_HEIGHT) - CFG_W'(1));
                default:
                    ;
            endcase
        end
    end

    assign row_end    = CMP_W'(col_reg) >= CMP_W'(width_m1_reg);
    assign frame_last = row_end && (row_reg >= height_m1_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_m1_reg  <= W_RESET_M1;
            height_m1_reg <= H_RESET_M1;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            width_m1_reg  <= width_m1_next;
            height_m1_reg <= height_m1_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    assign pos.col_odd   = col_reg[0];
    assign pos.row_odd   = row_reg[0];
    assign pos.frame_end = frame_last;
    assign slot          = col_reg[SLOT_W:1];

endmodule
`default_nettype wire

[hdl/rgb2yuv_matrix.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2yuv_matrix
// Input register and color matrix stage: luma and quarter chroma per pixel.
// ----------------------------------------------------------------------------
module rgb2yuv_matrix
    import rgb2yuv_pkg::*;
#(
    parameter int SLOT_W = 11
)
(
    input  wire logic              clk,
    input  wire logic              load_in,
    input  wire logic              load_mat,
    input  wire logic [PIX_W-1:0]  red_in,
    input  wire logic [PIX_W-1:0]  green_in,
    input  wire logic [PIX_W-1:0]  blue_in,
    input  wire pos_t              pos_in,
    input  wire logic [SLOT_W-1:0] slot_in,
    output      logic [SLOT_W-1:0] in_slot,
    output      pix_t              mat_pix,
    output      pos_t              mat_pos,
    output      logic [SLOT_W-1:0] mat_slot
);

    logic [PIX_W-1:0]  red_reg;
    logic [PIX_W-1:0]  green_reg;
    logic [PIX_W-1:0]  blue_reg;
    pos_t              in_pos_reg;
    logic [SLOT_W-1:0] in_slot_reg;
    pix_t              pix_reg;
    pix_t              pix_next;
    pos_t              mat_pos_reg;
    logic [SLOT_W-1:0] mat_slot_reg;
    logic [SUM_W-1:0]  r16;
    logic [SUM_W-1:0]  g16;
    logic [SUM_W-1:0]  b16;
    logic [SUM_W-1:0]  sum_y;
    logic [SUM_W-1:0]  sum_cb;
    logic [SUM_W-1:0]  sum_cr;

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            red_reg     <= red_in;
            green_reg   <= green_in;
            blue_reg    <= blue_in;
            in_pos_reg  <= pos_in;
            in_slot_reg <= slot_in;
        end
    end

    assign r16 = SUM_W'(red_reg);
    assign g16 = SUM_W'(green_reg);
    assign b16 = SUM_W'(blue_reg);

    // chroma sums are exact modulo 2^16 since the biased value stays positive
    assign sum_y  = COEF_YR * r16 + COEF_YG * g16 + COEF_YB * b16;
    assign sum_cb = CHROMA_BIAS + COEF_CBB * b16 - COEF_CBR * r16 - COEF_CBG * g16;
    assign sum_cr = CHROMA_BIAS + COEF_CRR * r16 - COEF_CRG * g16 - COEF_CRB * b16;

    // floor(c / 4) of the 8-bit chroma is the top six bits of the biased sum
    always_comb
    begin
        pix_next.y   = sum_y[SUM_W-1:SUM_W-PIX_W] + LUMA_OFFSET;
        pix_next.qcb = sum_cb[SUM_W-1:SUM_W-QUARTER_W];
        pix_next.qcr = sum_cr[SUM_W-1:SUM_W-QUARTER_W];
    end

    always_ff @(posedge clk)
    begin
        if (load_mat)
        begin
            pix_reg      <= pix_next;
            mat_pos_reg  <= in_pos_reg;
            mat_slot_reg <= in_slot_reg;
        end
    end

    assign in_slot  = in_slot_reg;
    assign mat_pix  = pix_reg;
    assign mat_pos  = mat_pos_reg;
    assign mat_slot = mat_slot_reg;

endmodule
`default_nettype wire

[hdl/rgb2yuv_chroma.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2yuv_chroma
// Line store of even-row chroma partial sums, block accumulation and the
// output register.
// ----------------------------------------------------------------------------
module rgb2yuv_chroma
    import rgb2yuv_pkg::*;
#(
    parameter int SLOT_W = 11
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_mat,
    input  wire logic              load_out,
    input  wire logic [SLOT_W-1:0] rd_slot,
    input  wire pix_t              mat_pix,
    input  wire pos_t              mat_pos,
    input  wire logic [SLOT_W-1:0] mat_slot,
    output      logic [PIX_W-1:0]  luma,
    output      logic              chroma_valid,
    output      logic [PIX_W-1:0]  cb_out,
    output      logic [PIX_W-1:0]  cr_out,
    output      logic              frame_end
);

    localparam int LINE_DEPTH = 2 ** SLOT_W;

    logic [ENTRY_W-1:0] line_mem [LINE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic [ENTRY_W-1:0] entry;

    logic [PIX_W-1:0]   pend_cb_reg;
    logic [PIX_W-1:0]   pend_cb_next;
    logic [PIX_W-1:0]   pend_cr_reg;
    logic [PIX_W-1:0]   pend_cr_next;
    logic [PIX_W-1:0]   qcb8;
    logic [PIX_W-1:0]   qcr8;
    logic [PIX_W-1:0]   row_cb;
    logic [PIX_W-1:0]   row_cr;
    logic [PIX_W-1:0]   blk_cb;
    logic [PIX_W-1:0]   blk_cr;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;

    logic [PIX_W-1:0]   luma_reg;
    logic               chroma_valid_reg;
    logic               chroma_valid_next;
    logic [PIX_W-1:0]   cb_reg;
    logic [PIX_W-1:0]   cb_next;
    logic [PIX_W-1:0]   cr_reg;
    logic [PIX_W-1:0]   cr_next;
    logic               frame_end_reg;

    assign qcb8 = PIX_W'(mat_pix.qcb);
    assign qcr8 = PIX_W'(mat_pix.qcr);

    // even row: pending + quarter, stored as 7-bit partials
    assign row_cb  = pend_cb_reg + qcb8;
    assign row_cr  = pend_cr_reg + qcr8;
    assign wr_data = {row_cr[PART_W-1:0], row_cb[PART_W-1:0]};
    assign wr_en   = load_out && !mat_pos.row_odd && mat_pos.col_odd;

    // the write of the previous pixel can hit the slot being read in the same cycle
    assign entry  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign blk_cb = PIX_W'(entry[PART_W-1:0]) + qcb8;
    assign blk_cr = PIX_W'(entry[ENTRY_W-1:PART_W]) + qcr8;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[mat_slot] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (load_mat)
        begin
            rd_data_reg  <= line_mem[rd_slot];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (load_mat)
            fwd_hit_reg <= wr_en && (mat_slot == rd_slot);
    end

    always_comb
    begin
        pend_cb_next      = pend_cb_reg;
        pend_cr_next      = pend_cr_reg;
        chroma_valid_next = 1'b0;
        cb_next           = '0;
        cr_next           = '0;
        if (!mat_pos.col_odd)
        begin
            if (mat_pos.row_odd)
            begin
                pend_cb_next = blk_cb;
                pend_cr_next = blk_cr;
            end
            else
            begin
                pend_cb_next = qcb8;
                pend_cr_next = qcr8;
            end
        end
        else if (mat_pos.row_odd)
        begin
            chroma_valid_next = 1'b1;
            cb_next           = row_cb;
            cr_next           = row_cr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cb_reg <= '0;
            pend_cr_reg <= '0;
        end
        else if (load_out)
        begin
            pend_cb_reg <= pend_cb_next;
            pend_cr_reg <= pend_cr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            luma_reg         <= mat_pix.y;
            chroma_valid_reg <= chroma_valid_next;
            cb_reg           <= cb_next;
            cr_reg           <= cr_next;
            frame_end_reg    <= mat_pos.frame_end;
        end
    end

    assign luma         = luma_reg;
    assign chroma_valid = chroma_valid_reg;
    assign cb_out       = cb_reg;
    assign cr_out       = cr_reg;
    assign frame_end    = frame_end_reg;

endmodule
`default_nettype wire

[sim/tb_rgb_to_yuv420_converter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv420_converter_top
// Streams RGB frames through the converter and checks every result beat
// (luma, block chroma, frame end) against a cycle-free predictor of the
// raster position, the even-row line store and the 2x2 chroma sums.
// Frame size is changed between frames and inside even rows, including
// odd, out-of-range and maximum sizes.
// ----------------------------------------------------------------------------
module tb_rgb_to_yuv420_converter_top;
    import rgb2yuv_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        logic             frame_end;
    } yuv_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_ready;
    logic [PIX_W-1:0]       red_in = '0;
    logic [PIX_W-1:0]       green_in = '0;
    logic [PIX_W-1:0]       blue_in = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [PIX_W-1:0]       luma;
    logic                   chroma_valid;
    logic [PIX_W-1:0]       cb_out;
    logic [PIX_W-1:0]       cr_out;
    logic                   frame_end;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    rgb_to_yuv420_converter_top dut (.*);

    // stimulus side
    rgb_pixel_t       pixel_queue [$];
    rgb_pixel_t       next_pixel;
    logic             pixel_beat = 1'b0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int               pixels_queued = 0;
    int               random_pixels = 0;
    logic [CFG_W-1:0] plan_width = CFG_W'(WIDTH_RESET);
    logic [CFG_W-1:0] plan_height = CFG_W'(HEIGHT_RESET);

    // predictor state
    logic [CFG_W-1:0]   width_setting = CFG_W'(WIDTH_RESET);
    logic [CFG_W-1:0]   height_setting = CFG_W'(HEIGHT_RESET);
    logic [13:0]        raster_col = '0;
    logic [ROW_W-1:0]   raster_row = '0;
    logic [PIX_W-1:0]   cb_partial = '0;
    logic [PIX_W-1:0]   cr_partial = '0;
    logic [ENTRY_W-1:0] chroma_line [MAX_WIDTH_DEFAULT/2];
    yuv_result_t        yuv_pending [$];
    yuv_result_t        oldest;

    int pixels_taken = 0;
    int results_checked = 0;
    int blocks_checked = 0;
    int frames_checked = 0;
    int cfg_writes = 0;
    int mismatch_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("rgb_to_yuv420_converter_top verification failed");
        $finish;
    end

    // even value in 2..hi
    function automatic int even_clamp(logic [CFG_W-1:0] v, int hi);
        int e;
        e = int'(v) & ~1;
        if (e < 2)
            e = 2;
        if (e > hi)
            e = hi & ~1;
        return e;
    endfunction

    task automatic convert_pixel(input rgb_pixel_t px);
        int               r, g, b, w, h;
        logic [PIX_W-1:0] cb_full, cr_full;
        logic [5:0]       qcb, qcr;
        logic [10:0]      slot;
        logic             row_end, frame_last;
        yuv_result_t      res;
        r = px.red;
        g = px.green;
        b = px.blue;
        res = '0;
        res.luma = PIX_W'((66 * r + 129 * g + 25 * b) >> 8) + 8'd16;
        // bias by 128 << 8 so the shift floors a non-negative sum
        cb_full = PIX_W'((-38 * r - 74 * g + 112 * b + 32768) >> 8);
        cr_full = PIX_W'((112 * r - 94 * g - 18 * b + 32768) >> 8);
        qcb = cb_full[7:2];
        qcr = cr_full[7:2];
        slot = raster_col[11:1];

        if (!raster_row[0])
        begin
            if (!raster_col[0])
            begin
                cb_partial = PIX_W'(qcb);
                cr_partial = PIX_W'(qcr);
            end
            else
            begin
                chroma_line[slot] = {PART_W'(cr_partial + qcr), PART_W'(cb_partial + qcb)};
            end
        end
        else
        begin
            if (!raster_col[0])
            begin
                cb_partial = PIX_W'(chroma_line[slot][PART_W-1:0]) + PIX_W'(qcb);
                cr_partial = PIX_W'(chroma_line[slot][ENTRY_W-1:PART_W]) + PIX_W'(qcr);
            end
            else
            begin
                res.chroma_valid = 1'b1;
                res.cb = cb_partial + PIX_W'(qcb);
                res.cr = cr_partial + PIX_W'(qcr);
            end
        end

        w = even_clamp(width_setting, MAX_WIDTH_DEFAULT);
        h = even_clamp(height_setting, MAX_HEIGHT);
        // rows and frames end when the count reaches or passes the size
        row_end = (int'(raster_col) + 1 >= w);
        frame_last = row_end && (int'(raster_row) + 1 >= h);
        res.frame_end = frame_last;
        if (row_end)
        begin
            raster_col = '0;
            raster_row = frame_last ? '0 : raster_row + 1'b1;
        end
        else
        begin
            raster_col = raster_col + 1'b1;
        end
        yuv_pending.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] exp_val,
                               input logic [PIX_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // monitor: config beats, pixel beats into the predictor, result checks
    always @(posedge clk)
    begin
        pixel_beat <= rst_n && pixel_valid && pixel_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_setting = cfg_data;
                else
                    height_setting = cfg_data;
                cfg_writes++;
            end
            if (pixel_valid && pixel_ready)
            begin
                convert_pixel({red_in, green_in, blue_in});
                pixels_taken++;
            end
            if (result_valid && result_ready)
            begin
                if (yuv_pending.size() == 0)
                begin
                    $error("result beat with no pixel outstanding");
                    mismatch_count++;
                end
                else
                begin
                    oldest = yuv_pending.pop_front();
                    check_field("luma", oldest.luma, luma);
                    check_field("chroma_valid", PIX_W'(oldest.chroma_valid),
                                PIX_W'(chroma_valid));
                    check_field("cb_out", oldest.cb, cb_out);
                    check_field("cr_out", oldest.cr, cr_out);
                    check_field("frame_end", PIX_W'(oldest.frame_end), PIX_W'(frame_end));
                    results_checked++;
                    if (oldest.chroma_valid)
                        blocks_checked++;
                    if (oldest.frame_end)
                        frames_checked++;
                end
            end
        end
    end

    // pixel driver: holds a beat until taken, then maybe idles
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
        end
        else if (!pixel_valid || pixel_beat)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_pixel = pixel_queue.pop_front();
                red_in <= next_pixel.red;
                green_in <= next_pixel.green;
                blue_in <= next_pixel.blue;
                pixel_valid <= 1'b1;
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        result_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic queue_pixel(input logic [PIX_W-1:0] r, g, b);
        pixel_queue.push_back({r, g, b});
        pixels_queued++;
    endtask

    function automatic logic [PIX_W-1:0] random_channel();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return PIX_W'($urandom_range(255));
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            queue_pixel(random_channel(), random_channel(), random_channel());
        random_pixels += count;
    endtask

    // mostly small even sizes, some odd or zero, a few larger
    function automatic logic [CFG_W-1:0] pick_dim(input int span);
        int sel;
        sel = $urandom_range(19);
        if (sel < 14)
            return CFG_W'(2 * $urandom_range(1, span / 2));
        if (sel < 18)
            return CFG_W'($urandom_range(15));
        return CFG_W'($urandom_range(span, 4 * span));
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixels_taken != pixels_queued || yuv_pending.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            plan_width = value;
        else
            plan_height = value;
    endtask

    // queue random pixels from (row, col) up to the end of the frame
    task automatic finish_frame(input int col, input int row);
        int w, h, count;
        w = even_clamp(plan_width, MAX_WIDTH_DEFAULT);
        h = even_clamp(plan_height, MAX_HEIGHT);
        count = (col + 1 >= w) ? 1 : w - col;
        if (row + 1 < h)
            count += (h - 1 - row) * w;
        queue_random(count);
    endtask

    task automatic random_frame();
        int w, h, rr, cc;
        if ($urandom_range(4) != 0)
        begin
            wait_drained();
            if ($urandom_range(2) != 0)
                write_reg(REG_FRAME_WIDTH, pick_dim(24));
            if ($urandom_range(2) != 0)
                write_reg(REG_FRAME_HEIGHT, pick_dim(6));
        end
        if ($urandom_range(3) == 0)
        begin
            // resize inside an even row so the odd row never reads a stale slot
            w = even_clamp(plan_width, MAX_WIDTH_DEFAULT);
            h = even_clamp(plan_height, MAX_HEIGHT);
            rr = 2 * $urandom_range((h - 2) / 2);
            cc = $urandom_range(w - 1);
            queue_random(rr * w + cc);
            wait_drained();
            if ($urandom_range(1) != 0)
                write_reg(REG_FRAME_WIDTH, pick_dim(24));
            else
                write_reg(REG_FRAME_HEIGHT, pick_dim(6));
            finish_frame(cc, rr);
        end
        else
        begin
            finish_frame(0, 0);
        end
    endtask

    initial
    begin
        send_idle_pct = 38;
        recv_idle_pct = 88;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 4x2 frame of primaries, secondaries, black and white
        write_reg(REG_FRAME_WIDTH, 13'd4);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd255);
        wait_drained();

        // odd sizes 1 and 3 both round to 2, giving a 2x2 frame
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        queue_pixel(8'd128, 8'd128, 8'd128);
        queue_pixel(8'd1, 8'd2, 8'd3);
        queue_pixel(8'd254, 8'd253, 8'd252);
        queue_pixel(8'd127, 8'd255, 8'd0);
        wait_drained();

        // zero width, all-ones height clamped to the maximum
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        queue_random(4);
        wait_drained();

        // widen mid-frame at an even row, then shrink below the column
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        queue_random(5);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 13'd2);
        queue_random(3);
        wait_drained();
        // height below the current row ends the frame on this row
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        queue_random(2);

        while (random_pixels < 384)
            random_frame();

        wait_drained();
        send_idle_pct = 88;
        recv_idle_pct = 38;
        while (random_pixels < 768)
            random_frame();

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (random_pixels < 1150)
            random_frame();

        wait_drained();
        repeat (16) @(posedge clk);
        $display("%0d pixels converted, %0d chroma blocks and %0d frame ends checked",
                 results_checked, blocks_checked, frames_checked);
        $display("%0d size register writes, sizes from 2 up to 4096 in both directions",
                 cfg_writes);
        if (mismatch_count == 0)
            $display("rgb_to_yuv420_converter_top verification clean");
        else
            $display("rgb_to_yuv420_converter_top verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/rgb2yuv_pkg.sv
hdl/rgb2yuv_pos.sv
hdl/rgb2yuv_matrix.sv
hdl/rgb2yuv_chroma.sv
hdl/rgb_to_yuv420_converter_top.sv
sim/tb_rgb_to_yuv420_converter_top.sv
